[sv/lorf_pkg.sv]
// Shared types and constants for the longest-ones-run-with-flips block.
`timescale 1ns / 1ps

package lorf_pkg;

  // Element position and window length width
  localparam int unsigned PosW      = 16;
  // Saturation point of the element position
  localparam int unsigned MaxLen    = 65535;
  // Largest legal flip count and the ring that covers it
  localparam int unsigned MaxFlips  = 15;
  localparam int unsigned RingDepth = MaxFlips + 1;
  localparam int unsigned RingAw    = $clog2(RingDepth);
  // Flip count register width
  localparam int unsigned FlipsW    = 4;
  // Zero counter saturates at the ring depth
  localparam int unsigned ZcntW     = $clog2(RingDepth + 1);

  typedef logic [PosW-1:0]   pos_t;
  typedef logic [RingAw-1:0] ring_ptr_t;
  typedef logic [FlipsW-1:0] flips_t;
  typedef logic [ZcntW-1:0]  zcnt_t;

  // Per-item control carried from the ring-access stage to the window stage
  typedef struct packed {
    logic upd;       // element entered a window (position not saturated)
    logic use_left;  // window starts after a stored zero
    logic last;      // final element of the array
    logic ovf;       // array has overrun MaxLen
    pos_t pos;       // index of this element
  } win_ctl_t;

endpackage

[sv/lorf_in_if.sv]
// Input channel: one array element per transaction.
`timescale 1ns / 1ps

interface lorf_in_if;
  logic valid;
  logic ready;
  logic bit_value;
  logic is_last;

  modport source (output valid, output bit_value, output is_last, input ready);
  modport sink   (input valid, input bit_value, input is_last, output ready);
endinterface

[sv/lorf_out_if.sv]
// Output channel: one result per array.
`timescale 1ns / 1ps

interface lorf_out_if;
  logic                       valid;
  logic                       ready;
  logic [lorf_pkg::PosW-1:0]  best_length;
  logic                       overflow;

  modport source (output valid, output best_length, output overflow, input ready);
  modport sink   (input valid, input best_length, input overflow, output ready);
endinterface

[sv/longest_ones_run_with_flips.sv]
// Top level: longest window of ones holding at most max_flips zeros.
// A finished result passes the window-stage register, then the output register.
// Throughput: one element per cycle; the ring memory is read once and written at most once
// per element, and a same-cycle write to the read entry is forwarded.
// The input stalls only while a finished result sits unread and another last element waits.
// Reset (async, active low) clears counters, flip count and output valid; no clearing pass.
`timescale 1ns / 1ps

module longest_ones_run_with_flips (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  lorf_pkg::flips_t  cfg_wdata_i,
  lorf_in_if.sink           in_i,
  lorf_out_if.source        out_o
);
  import lorf_pkg::*;

  // Configuration and front-stage state
  flips_t    flips_q;
  pos_t      pos_q, pos_d;
  ring_ptr_t wp_q, wp_d;
  zcnt_t     zcnt_q, zcnt_d;
  logic      ovf_q, ovf_d;

  // Window stage
  logic      s1_valid_q;
  win_ctl_t  s1_q, s1_d;
  pos_t      best_q;
  pos_t      ring_rdata;

  // Output register
  logic      out_valid_q;
  pos_t      out_len_q;
  logic      out_ovf_q;

  logic      in_fire, out_fire, s1_move;
  logic      sat, is_zero;
  ring_ptr_t wp_new, rd_addr;
  zcnt_t     zcnt_new;
  pos_t      win_len, best_cand;

  // Handshake
  assign out_fire = out_valid_q && out_o.ready;
  assign s1_move  = s1_valid_q && !(s1_q.last && out_valid_q && !out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_move;
  assign in_fire  = in_i.valid && in_i.ready;

  // Front stage: position, ring pointer, zero count and ring address
  always_comb begin
    sat      = (pos_q == pos_t'(MaxLen));
    is_zero  = !in_i.bit_value && !sat;
    wp_new   = is_zero ? wp_q + ring_ptr_t'(1) : wp_q;
    zcnt_new = (is_zero && (zcnt_q != zcnt_t'(RingDepth))) ? zcnt_q + zcnt_t'(1) : zcnt_q;
    // entry of the (max_flips+1)-th most recent zero
    rd_addr  = wp_new + ring_ptr_t'(~flips_q);

    s1_d.upd      = !sat;
    s1_d.use_left = (zcnt_new > zcnt_t'(flips_q));
    s1_d.last     = in_i.is_last;
    s1_d.ovf      = ovf_q || sat;
    s1_d.pos      = pos_q;

    pos_d  = sat ? pos_q : pos_q + pos_t'(1);
    wp_d   = wp_new;
    zcnt_d = zcnt_new;
    ovf_d  = ovf_q || sat;
    if (in_i.is_last) begin
      pos_d  = '0;
      wp_d   = '0;
      zcnt_d = '0;
      ovf_d  = 1'b0;
    end
  end

  lorf_ring u_ring (
    .clk_i     (clk_i),
    .wr_en_i   (in_fire && is_zero),
    .wr_addr_i (wp_q),
    .wr_data_i (pos_q),
    .rd_en_i   (in_fire),
    .rd_addr_i (rd_addr),
    .rd_data_o (ring_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flips_q <= '0;
      pos_q   <= '0;
      wp_q    <= '0;
      zcnt_q  <= '0;
      ovf_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        flips_q <= cfg_wdata_i;
      end
      if (in_fire) begin
        pos_q  <= pos_d;
        wp_q   <= wp_d;
        zcnt_q <= zcnt_d;
        ovf_q  <= ovf_d;
      end
    end
  end

  // Window stage: length from the stored zero, running best
  always_comb begin
    // window after the stored zero z ends at pos: length pos - z
    win_len   = s1_q.use_left ? s1_q.pos - ring_rdata : s1_q.pos + pos_t'(1);
    best_cand = (s1_q.upd && (win_len > best_q)) ? win_len : best_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      best_q     <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        best_q <= s1_q.last ? '0 : best_cand;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= s1_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_move && s1_q.last) begin
      out_valid_q <= 1'b1;
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move && s1_q.last) begin
      out_len_q <= best_cand;
      out_ovf_q <= s1_q.ovf;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.best_length = out_len_q;
  assign out_o.overflow    = out_ovf_q;

endmodule

[sv/lorf_ring.sv]
// Ring of recent zero positions: synchronous memory with write-to-read forwarding.
`timescale 1ns / 1ps

module lorf_ring (
  input  logic                 clk_i,
  input  logic                 wr_en_i,
  input  lorf_pkg::ring_ptr_t  wr_addr_i,
  input  lorf_pkg::pos_t       wr_data_i,
  input  logic                 rd_en_i,
  input  lorf_pkg::ring_ptr_t  rd_addr_i,
  output lorf_pkg::pos_t       rd_data_o
);
  import lorf_pkg::*;

  pos_t mem [RingDepth];
  pos_t rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read; a same-cycle write to the read entry is forwarded
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_data_q <= wr_data_i;
      end else begin
        rd_data_q <= mem[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[sv/lorf_checker.sv]
// Port-level checks for the longest-ones-run-with-flips block, bound to the top level.
`timescale 1ns / 1ps

module lorf_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_i,
  input logic                  in_is_last_i,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic [lorf_pkg::PosW-1:0] out_best_length_i,
  input logic                  out_overflow_i
);
  import lorf_pkg::*;

  // A pending result holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped before transaction");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_best_length_i) && $stable(out_overflow_i))
    else $error("result payload changed while stalled");

  // Input is never blocked while the output register is empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output register");

  // A last element taken with an empty output shows a result once it has passed the window stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_is_last_i && !out_valid_i |-> ##2 out_valid_i)
    else $error("result missing after last element");

endmodule

bind longest_ones_run_with_flips lorf_checker u_lorf_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .in_is_last_i      (in_i.is_last),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_best_length_i (out_o.best_length),
  .out_overflow_i    (out_o.overflow)
);

[tb/longest_ones_run_with_flips_checker.sv]
// Scoreboard for the longest-ones-run block: predicts each array's best window and checks it.
`timescale 1ns / 1ps

module longest_ones_run_with_flips_checker (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  lorf_pkg::flips_t cfg_wdata_i,
  lorf_in_if               in_i,
  lorf_out_if              out_i,
  output int               fail_count_o,
  output int               pending_o,
  output int               results_o
);
  import lorf_pkg::*;

  localparam int ReportLimit = 10;

  typedef struct packed {
    pos_t best_length;
    logic overflow;
  } run_result_t;

  // Shadow copy of the window state
  flips_t    flips_q;
  pos_t      elem_pos;
  pos_t      zero_ring [RingDepth];
  ring_ptr_t ring_wr;
  zcnt_t     zero_cnt;
  pos_t      best_len;
  logic      ovf_seen;

  run_result_t expected_runs [$];
  int          mismatches;
  int          checked;

  task automatic clear_array();
    elem_pos = '0;
    ring_wr  = '0;
    zero_cnt = '0;
    best_len = '0;
    ovf_seen = 1'b0;
  endtask

  // Fold one element into the window; on the last one queue the array's result
  task automatic absorb_element(input logic bit_v, input logic last_v);
    int unsigned idx_pos;
    int unsigned left;
    int unsigned span;
    ring_ptr_t   idx;
    run_result_t res;
    if (elem_pos >= pos_t'(MaxLen)) begin
      // overrun: element is dropped, only the flag moves
      ovf_seen = 1'b1;
    end else begin
      idx_pos  = 32'(elem_pos);
      elem_pos = elem_pos + pos_t'(1);
      if (!bit_v) begin
        zero_ring[ring_wr] = pos_t'(idx_pos);
        ring_wr = ring_wr + ring_ptr_t'(1);
        if (zero_cnt < zcnt_t'(RingDepth)) zero_cnt = zero_cnt + zcnt_t'(1);
      end
      // window opens just past the zero that lies k+1 back
      if (zero_cnt > zcnt_t'(flips_q)) begin
        idx  = ring_wr - ring_ptr_t'(1) - ring_ptr_t'(flips_q);
        left = 32'(zero_ring[idx]) + 1;
      end else begin
        left = 0;
      end
      span = idx_pos + 1 - left;
      if (span > 32'(best_len)) best_len = pos_t'(span);
    end
    if (last_v) begin
      res.best_length = best_len;
      res.overflow    = ovf_seen;
      expected_runs.push_back(res);
      clear_array();
    end
  endtask

  task automatic check_result(input pos_t got_len, input logic got_ovf);
    run_result_t want;
    checked++;
    if (expected_runs.size() == 0) begin
      mismatches++;
      if (mismatches <= ReportLimit)
        $display("[%0t] unexpected result: best_length=%0d overflow=%0b",
                 $realtime, got_len, got_ovf);
    end else begin
      want = expected_runs.pop_front();
      if (got_len !== want.best_length || got_ovf !== want.overflow) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display({"[%0t] result %0d: expected best_length=%0d overflow=%0b, ",
                    "got best_length=%0d overflow=%0b"},
                   $realtime, checked, want.best_length, want.overflow, got_len, got_ovf);
      end
    end
  endtask

  // Watch both channels and the config port at every edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flips_q = '0;
      clear_array();
      expected_runs.delete();
      mismatches = 0;
      checked    = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
      results_o    <= 0;
    end else begin
      if (out_i.valid && out_i.ready) check_result(out_i.best_length, out_i.overflow);
      if (in_i.valid && in_i.ready) absorb_element(in_i.bit_value, in_i.is_last);
      if (cfg_we_i) flips_q = cfg_wdata_i;
      fail_count_o <= mismatches;
      pending_o    <= expected_runs.size();
      results_o    <= checked;
    end
  end

endmodule

[tb/longest_ones_run_with_flips_tb.sv]
// Testbench top for the longest-ones-run block: stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps

module longest_ones_run_with_flips_tb;
  import lorf_pkg::*;

  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned MaxIdle     = 12;
  localparam int unsigned HoldCycles  = 400;
  // leave margin after the last result before touching the register
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned RandItems   = 1500;

  logic   clk_i;
  logic   rst_ni;
  logic   cfg_we;
  flips_t cfg_wdata;

  lorf_in_if  in_ch ();
  lorf_out_if out_ch ();

  int          fail_count;
  int          pending;
  int          results_seen;
  bit          tx_idle_on;
  bit          rx_idle_on;
  bit          rx_hold_req;
  int unsigned cycle_cnt = 0;
  int unsigned elems_sent = 0;
  int unsigned arrays_sent = 0;
  int unsigned cfg_writes = 0;

  longest_ones_run_with_flips DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  longest_ones_run_with_flips_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_i         (in_ch),
    .out_i        (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .results_o    (results_seen)
  );

  // 8 ns clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side: random stalls per transaction, one long hold-off on request
  initial begin
    int unsigned stall;
    out_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        stall = HoldCycles;
      end else begin
        stall = rx_idle_on ? $urandom_range(0, MaxIdle) : 0;
      end
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
    end
  end

  // One element transaction, with a random gap in front of it
  task automatic send_element(input bit bit_v, input bit last_v);
    int unsigned gap;
    gap = tx_idle_on ? $urandom_range(0, MaxIdle) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.bit_value <= bit_v;
    in_ch.is_last   <= last_v;
    do @(posedge clk_i); while (!in_ch.ready);
    elems_sent++;
    if (last_v) arrays_sent++;
  endtask

  // count random bits with the given share of ones, optionally closing the array
  task automatic send_bits(input int unsigned count, input int unsigned ones_pct,
                           input bit close_array);
    for (int unsigned i = 0; i < count; i++)
      send_element($urandom_range(0, 99) < ones_pct, close_array && (i == count - 1));
  endtask

  // Register write only once the block has drained
  task automatic set_flips(input flips_t k);
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= k;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    cfg_writes++;
  endtask

  function automatic flips_t pick_flips();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return flips_t'(MaxFlips);
      default: return flips_t'($urandom_range(0, MaxFlips));
    endcase
  endfunction

  function automatic int unsigned pick_density();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 100;
      2:       return 90;
      3:       return 75;
      default: return $urandom_range(0, 100);
    endcase
  endfunction

  // Main stimulus
  initial begin
    int unsigned rand_items;
    int unsigned len;
    int unsigned pct;
    int unsigned split_at;
    int unsigned phase_left;
    bit          pressure_done;
    bit          saved_idle;

    rst_ni          = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.bit_value = 1'b0;
    in_ch.is_last   = 1'b0;
    tx_idle_on      = 1'b1;
    rx_idle_on      = 1'b1;
    rx_hold_req     = 1'b0;
    rand_items      = 0;
    phase_left      = 0;
    pressure_done   = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset value of k, single-element arrays, a short mixed one
    send_element(1'b1, 1'b1);
    send_element(1'b0, 1'b1);
    send_element(1'b1, 1'b0);
    send_element(1'b0, 1'b0);
    send_element(1'b1, 1'b0);
    send_element(1'b1, 1'b1);

    // Largest k: every zero fits
    set_flips(flips_t'(MaxFlips));
    send_element(1'b0, 1'b0);
    send_element(1'b0, 1'b0);
    send_element(1'b1, 1'b0);
    send_element(1'b0, 1'b1);

    set_flips(flips_t'(2));
    send_element(1'b0, 1'b0);
    send_element(1'b1, 1'b0);
    send_element(1'b0, 1'b0);
    send_element(1'b0, 1'b0);
    send_element(1'b1, 1'b0);
    send_element(1'b1, 1'b0);
    send_element(1'b0, 1'b0);
    send_element(1'b1, 1'b1);

    // k changed in the middle of an array
    set_flips(flips_t'(1));
    send_element(1'b1, 1'b0);
    send_element(1'b0, 1'b0);
    send_element(1'b1, 1'b0);
    send_element(1'b1, 1'b0);
    send_element(1'b0, 1'b0);
    set_flips(flips_t'(3));
    send_element(1'b0, 1'b0);
    send_element(1'b1, 1'b0);
    send_element(1'b1, 1'b1);

    // Random arrays in phases of differing k and pacing
    while (rand_items < RandItems) begin
      if (phase_left == 0) begin
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on = ($urandom_range(0, 3) != 0);
        set_flips(pick_flips());
        phase_left = $urandom_range(3, 10);
      end

      // Back-pressure burst: output held off while short arrays keep coming
      if (!pressure_done && rand_items >= RandItems / 2) begin
        saved_idle  = tx_idle_on;
        tx_idle_on  = 1'b0;
        rx_hold_req = 1'b1;
        repeat (30) begin
          len = $urandom_range(1, 3);
          send_bits(len, 50, 1'b1);
          rand_items += len;
        end
        tx_idle_on    = saved_idle;
        pressure_done = 1'b1;
      end

      len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200) : $urandom_range(1, 40);
      pct = pick_density();
      if (len > 1 && $urandom_range(0, 5) == 0) begin
        split_at = $urandom_range(1, len - 1);
        send_bits(split_at, pct, 1'b0);
        set_flips(pick_flips());
        send_bits(len - split_at, pct, 1'b1);
      end else begin
        send_bits(len, pct, 1'b1);
      end
      rand_items += len;
      phase_left--;
    end

    // Drain and report
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Run covered %0d elements in %0d arrays, %0d results compared, %0d k settings",
             elems_sent, arrays_sent, results_seen, cfg_writes);
    $display("including mid-array k changes and a %0d-cycle output hold-off", HoldCycles);
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

[files.f]
sv/lorf_pkg.sv
sv/lorf_in_if.sv
sv/lorf_out_if.sv
sv/lorf_ring.sv
sv/longest_ones_run_with_flips.sv
sv/lorf_checker.sv
tb/longest_ones_run_with_flips_checker.sv
tb/longest_ones_run_with_flips_tb.sv
